>>> design/lobl_pkg.sv
// ----------------------------------------------------------------------------
// lobl_pkg
// Shared types and constants of the limit order book level engine.
// ----------------------------------------------------------------------------
package lobl_pkg;

   localparam int DEF_PRICE_LEVELS = 1024;
   localparam int DEF_LEVEL_DEPTH  = 16;
   localparam int DEF_ORDER_IDS    = 65536;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_CANCEL  = 3'd1;
   localparam logic [2:0] OP_REM_BID = 3'd2;
   localparam logic [2:0] OP_REM_ASK = 3'd3;
   localparam logic [2:0] OP_CHECK   = 3'd4;

   localparam logic SIDE_BUY = 1'b0;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_MOD, S_DISPATCH, S_ADD_RD, S_ADD_WR,
      S_CAN_RD, S_CAN_IDX, S_CAN_CNT, S_SRCH_RD, S_SRCH_CMP,
      S_SHIFT_RD, S_SHIFT_WR, S_AFTER, S_SCAN_RD, S_SCAN_CHK,
      S_TOP_RD, S_TOP_CHK, S_CHK_RD, S_CHK_DATA, S_FIN_RD, S_FIN_OUT
   } ctl_state_type;

   typedef enum logic [4:0] {
      DP_NONE, DP_CLEAR, DP_LATCH, DP_MOD, DP_ADD_RD, DP_ADD_WR, DP_SET_FULL,
      DP_CAN_RD, DP_CAN_IDX, DP_NOT_FOUND, DP_CAN_CNT, DP_SRCH_RD, DP_SRCH_CMP,
      DP_SHIFT_RD, DP_SHIFT_WR, DP_SCAN_RD, DP_SCAN_CHK, DP_TOP_RD, DP_TOP_CHK,
      DP_CHK_RD, DP_CHK_DATA, DP_FIN_RD, DP_FIN_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] operation;
      logic       mod_skip;
      logic       mod_last;
      logic       clear_done;
      logic       cnt_full;
      logic       idx_valid;
      logic       pos_lt_cnt;
      logic       id_match;
      logic       shift_more;
      logic       need_rescan;
      logic       scan_stop;
      logic       top_empty;
      logic       out_busy;
   } dp_status_type;

endpackage

>>> design/lobl_ctrl.sv
// ----------------------------------------------------------------------------
// lobl_ctrl
// Sequencer of the order book: steps each transaction through the datapath.
// ----------------------------------------------------------------------------
module lobl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  lobl_pkg::dp_status_type status,
   output lobl_pkg::dp_cmd_type    cmd
);
   import lobl_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = DP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = DP_CLEAR;
            if (status.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = DP_LATCH;
               state_in = status.mod_skip ? S_DISPATCH : S_MOD;
            end
         end
         S_MOD: begin
            cmd.op = DP_MOD;
            if (status.mod_last) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            priority case (status.operation)
               OP_ADD:                 state_in = S_ADD_RD;
               OP_CANCEL:              state_in = S_CAN_RD;
               OP_REM_BID, OP_REM_ASK: state_in = S_TOP_RD;
               OP_CHECK:               state_in = S_CHK_RD;
               default:                state_in = S_FIN_RD;
            endcase
         end
         S_ADD_RD: begin
            cmd.op   = DP_ADD_RD;
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            cmd.op   = status.cnt_full ? DP_SET_FULL : DP_ADD_WR;
            state_in = S_FIN_RD;
         end
         S_CAN_RD: begin
            cmd.op   = DP_CAN_RD;
            state_in = S_CAN_IDX;
         end
         S_CAN_IDX: begin
            if (status.idx_valid) begin
               cmd.op   = DP_CAN_IDX;
               state_in = S_CAN_CNT;
            end else begin
               cmd.op   = DP_NOT_FOUND;
               state_in = S_FIN_RD;
            end
         end
         S_CAN_CNT: begin
            cmd.op   = DP_CAN_CNT;
            state_in = S_SRCH_RD;
         end
         S_SRCH_RD: begin
            if (status.pos_lt_cnt) begin
               cmd.op   = DP_SRCH_RD;
               state_in = S_SRCH_CMP;
            end else begin
               cmd.op   = DP_NOT_FOUND;
               state_in = S_FIN_RD;
            end
         end
         S_SRCH_CMP: begin
            cmd.op   = DP_SRCH_CMP;
            state_in = status.id_match ? S_SHIFT_RD : S_SRCH_RD;
         end
         S_SHIFT_RD: begin
            cmd.op   = DP_SHIFT_RD;
            state_in = status.shift_more ? S_SHIFT_WR : S_AFTER;
         end
         S_SHIFT_WR: begin
            cmd.op   = DP_SHIFT_WR;
            state_in = S_SHIFT_RD;
         end
         S_AFTER: begin
            state_in = status.need_rescan ? S_SCAN_RD : S_FIN_RD;
         end
         S_SCAN_RD: begin
            cmd.op   = DP_SCAN_RD;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            cmd.op   = DP_SCAN_CHK;
            state_in = status.scan_stop ? S_FIN_RD : S_SCAN_RD;
         end
         S_TOP_RD: begin
            cmd.op   = DP_TOP_RD;
            state_in = S_TOP_CHK;
         end
         S_TOP_CHK: begin
            cmd.op   = DP_TOP_CHK;
            state_in = status.top_empty ? S_FIN_RD : S_SHIFT_RD;
         end
         S_CHK_RD: begin
            cmd.op   = DP_CHK_RD;
            state_in = S_CHK_DATA;
         end
         S_CHK_DATA: begin
            cmd.op   = DP_CHK_DATA;
            state_in = S_FIN_RD;
         end
         S_FIN_RD: begin
            cmd.op   = DP_FIN_RD;
            state_in = S_FIN_OUT;
         end
         S_FIN_OUT: begin
            if (status.out_busy) begin
               cmd.op = DP_FIN_RD;
            end else begin
               cmd.op   = DP_FIN_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

endmodule

>>> design/lobl_datapath.sv
// ----------------------------------------------------------------------------
// lobl_datapath
// Level queues, level counts, id index, cancel marks, best pointers and
// the result register of the order book.
// ----------------------------------------------------------------------------
module lobl_datapath #(
   parameter int PRICE_LEVELS = lobl_pkg::DEF_PRICE_LEVELS,
   parameter int LEVEL_DEPTH  = lobl_pkg::DEF_LEVEL_DEPTH,
   parameter int ORDER_IDS    = lobl_pkg::DEF_ORDER_IDS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lobl_pkg::dp_cmd_type    cmd,
   output lobl_pkg::dp_status_type status,
   input  logic [2:0]              req_operation,
   input  logic [15:0]             req_order_id,
   input  logic [9:0]              req_price_level,
   input  logic                    req_side,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic                    rsp_cancel_marked,
   output logic                    rsp_bid_valid,
   output logic [15:0]             rsp_bid_order_id,
   output logic [9:0]              rsp_bid_price_level,
   output logic                    rsp_ask_valid,
   output logic [15:0]             rsp_ask_order_id,
   output logic [9:0]              rsp_ask_price_level
);
   import lobl_pkg::*;

   localparam int LW  = $clog2(PRICE_LEVELS);
   localparam int CW  = $clog2(LEVEL_DEPTH + 1);
   localparam int AW  = $clog2(PRICE_LEVELS * LEVEL_DEPTH);
   localparam int IW  = $clog2(ORDER_IDS);
   localparam int XW  = LW + 2;
   localparam int CLN = (PRICE_LEVELS > ORDER_IDS) ? PRICE_LEVELS : ORDER_IDS;
   localparam int CLW = $clog2(CLN);
   localparam logic MOD_SKIP = (ORDER_IDS >= 65536);
   // reciprocal of ORDER_IDS, exact quotient for any 16-bit id
   localparam int     MSH   = 16 + $clog2(ORDER_IDS);
   localparam longint MREC  = ((longint'(1) << MSH) + longint'(ORDER_IDS) - 1) /
                              longint'(ORDER_IDS);
   localparam logic [17:0] MRECV = 18'(MREC);

   // memories
   logic [CW-1:0] bcnt_mem [PRICE_LEVELS];
   logic [CW-1:0] acnt_mem [PRICE_LEVELS];
   logic [15:0]   bid_mem  [PRICE_LEVELS*LEVEL_DEPTH];
   logic [15:0]   ask_mem  [PRICE_LEVELS*LEVEL_DEPTH];
   logic [XW-1:0] idx_mem  [ORDER_IDS];
   logic          mark_mem [ORDER_IDS];

   logic [CW-1:0] bcnt_rd_ff, acnt_rd_ff;
   logic [15:0]   bid_rd_ff, ask_rd_ff;
   logic [XW-1:0] idx_rd_ff;
   logic          mark_rd_ff;

   logic [LW-1:0] bcnt_raddr, acnt_raddr, cnt_waddr;
   logic          bcnt_we, acnt_we;
   logic [CW-1:0] cnt_wdata;
   logic [AW-1:0] bid_raddr, ask_raddr, id_waddr;
   logic          bid_we, ask_we;
   logic [15:0]   id_wdata;
   logic [IW-1:0] idx_addr, idx_waddr;
   logic          idx_we, mark_we, mark_wdata;
   logic [XW-1:0] idx_wdata;

   // working registers
   logic [2:0]     op_ff, op_in;
   logic [15:0]    oid_ff, oid_in;
   logic [15:0]    rem_ff, rem_in;
   logic [15:0]    quo_ff, quo_in;
   logic [3:0]     mod_k_ff, mod_k_in;
   logic [LW-1:0]  best_bid_ff, best_bid_in;
   logic [LW-1:0]  best_ask_ff, best_ask_in;
   logic [LW-1:0]  wlvl_ff, wlvl_in;
   logic           wside_ff, wside_in;
   logic [CW-1:0]  pos_ff, pos_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [1:0]     stat_ff, stat_in;
   logic           marked_ff, marked_in;
   logic [CLW-1:0] clr_ff, clr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     o_status_ff, o_status_in;
   logic           o_marked_ff, o_marked_in;
   logic           o_bvalid_ff, o_bvalid_in;
   logic [15:0]    o_bid_ff, o_bid_in;
   logic [9:0]     o_bprice_ff, o_bprice_in;
   logic           o_avalid_ff, o_avalid_in;
   logic [15:0]    o_ask_ff, o_ask_in;
   logic [9:0]     o_aprice_ff, o_aprice_in;

   logic [CW-1:0] cnt_rd;
   logic [15:0]   id_rd;
   logic [LW-1:0] lvl_sat;
   logic [33:0]   mod_prod;
   logic [LW-1:0] best_side;
   logic          side_end;

   function automatic logic [AW-1:0] qaddr(input logic [LW-1:0] lvl,
                                           input logic [CW-1:0] pos);
      qaddr = AW'(lvl) * AW'(LEVEL_DEPTH) + AW'(pos);
   endfunction

   assign cnt_rd    = wside_ff ? acnt_rd_ff : bcnt_rd_ff;
   assign id_rd     = wside_ff ? ask_rd_ff : bid_rd_ff;
   assign idx_addr  = IW'(rem_ff);
   assign lvl_sat   = ({7'd0, req_price_level} >= 17'(PRICE_LEVELS)) ?
                      LW'(PRICE_LEVELS - 1) : LW'(req_price_level);
   assign mod_prod  = 34'(rem_ff) * 34'(MRECV);
   assign best_side = wside_ff ? best_ask_ff : best_bid_ff;
   assign side_end  = wside_ff ? (best_ask_ff == LW'(PRICE_LEVELS - 1))
                               : (best_bid_ff == '0);

   always_comb begin
      status.operation   = op_ff;
      status.mod_skip    = MOD_SKIP;
      status.mod_last    = (mod_k_ff == 4'd0);
      status.clear_done  = (clr_ff == CLW'(CLN - 1));
      status.cnt_full    = (cnt_rd >= CW'(LEVEL_DEPTH));
      status.idx_valid   = idx_rd_ff[XW-1];
      status.pos_lt_cnt  = (pos_ff < cnt_ff);
      status.id_match    = (id_rd == oid_ff);
      status.shift_more  = ({1'b0, pos_ff} + 1'b1) < {1'b0, cnt_ff};
      status.need_rescan = (op_ff == OP_REM_BID) || (op_ff == OP_REM_ASK) ||
                           ((cnt_ff == '0) && (wlvl_ff == best_side));
      status.scan_stop   = (cnt_rd != '0) || side_end;
      status.top_empty   = (cnt_rd == '0);
      status.out_busy    = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      op_in        = op_ff;
      oid_in       = oid_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      mod_k_in     = mod_k_ff;
      best_bid_in  = best_bid_ff;
      best_ask_in  = best_ask_ff;
      wlvl_in      = wlvl_ff;
      wside_in     = wside_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      stat_in      = stat_ff;
      marked_in    = marked_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_status_in  = o_status_ff;
      o_marked_in  = o_marked_ff;
      o_bvalid_in  = o_bvalid_ff;
      o_bid_in     = o_bid_ff;
      o_bprice_in  = o_bprice_ff;
      o_avalid_in  = o_avalid_ff;
      o_ask_in     = o_ask_ff;
      o_aprice_in  = o_aprice_ff;

      bcnt_raddr = wlvl_ff;
      acnt_raddr = wlvl_ff;
      cnt_waddr  = wlvl_ff;
      bcnt_we    = 1'b0;
      acnt_we    = 1'b0;
      cnt_wdata  = cnt_rd + 1'b1;
      bid_raddr  = qaddr(wlvl_ff, pos_ff);
      ask_raddr  = qaddr(wlvl_ff, pos_ff);
      id_waddr   = qaddr(wlvl_ff, pos_ff);
      bid_we     = 1'b0;
      ask_we     = 1'b0;
      id_wdata   = id_rd;
      idx_waddr  = idx_addr;
      idx_we     = 1'b0;
      idx_wdata  = {1'b1, wside_ff, wlvl_ff};
      mark_we    = 1'b0;
      mark_wdata = 1'b1;

      unique case (cmd.op)
         DP_NONE: begin
         end
         DP_CLEAR: begin
            cnt_waddr = LW'(clr_ff);
            cnt_wdata = '0;
            idx_waddr = IW'(clr_ff);
            idx_wdata = '0;
            mark_wdata = 1'b0;
            if (32'(clr_ff) < PRICE_LEVELS) begin
               bcnt_we = 1'b1;
               acnt_we = 1'b1;
            end
            if (32'(clr_ff) < ORDER_IDS) begin
               idx_we  = 1'b1;
               mark_we = 1'b1;
            end
            clr_in = clr_ff + 1'b1;
         end
         DP_LATCH: begin
            op_in     = req_operation;
            oid_in    = req_order_id;
            rem_in    = req_order_id;
            mod_k_in  = 4'd1;
            wside_in  = req_side;
            wlvl_in   = lvl_sat;
            stat_in   = ST_DONE;
            marked_in = 1'b0;
         end
         DP_MOD: begin
            // quotient first, then the remainder from it
            if (mod_k_ff != 4'd0) quo_in = 16'(mod_prod >> MSH);
            else rem_in = rem_ff - quo_ff * 16'(ORDER_IDS);
            mod_k_in = mod_k_ff - 1'b1;
         end
         DP_ADD_RD: begin
         end
         DP_ADD_WR: begin
            id_waddr = qaddr(wlvl_ff, cnt_rd);
            id_wdata = oid_ff;
            if (wside_ff == SIDE_BUY) begin
               bid_we  = 1'b1;
               bcnt_we = 1'b1;
               if (wlvl_ff > best_bid_ff) best_bid_in = wlvl_ff;
            end else begin
               ask_we  = 1'b1;
               acnt_we = 1'b1;
               if (wlvl_ff < best_ask_ff) best_ask_in = wlvl_ff;
            end
            idx_we = 1'b1;
         end
         DP_SET_FULL: stat_in = ST_FULL;
         DP_CAN_RD: mark_we = 1'b1;
         DP_CAN_IDX: begin
            wside_in   = idx_rd_ff[XW-2];
            wlvl_in    = idx_rd_ff[LW-1:0];
            bcnt_raddr = idx_rd_ff[LW-1:0];
            acnt_raddr = idx_rd_ff[LW-1:0];
            pos_in     = '0;
         end
         DP_NOT_FOUND: stat_in = ST_NOT_FOUND;
         DP_CAN_CNT: cnt_in = cnt_rd;
         DP_SRCH_RD: begin
         end
         DP_SRCH_CMP: begin
            if (id_rd == oid_ff) begin
               idx_we     = 1'b1;
               idx_wdata  = {1'b0, wside_ff, wlvl_ff};
               mark_we    = 1'b1;
               mark_wdata = 1'b0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         DP_SHIFT_RD: begin
            bid_raddr = qaddr(wlvl_ff, pos_ff + 1'b1);
            ask_raddr = qaddr(wlvl_ff, pos_ff + 1'b1);
            if (!status.shift_more) begin
               cnt_wdata = cnt_ff - 1'b1;
               cnt_in    = cnt_ff - 1'b1;
               bcnt_we   = (wside_ff == SIDE_BUY);
               acnt_we   = (wside_ff != SIDE_BUY);
            end
         end
         DP_SHIFT_WR: begin
            bid_we = (wside_ff == SIDE_BUY);
            ask_we = (wside_ff != SIDE_BUY);
            pos_in = pos_ff + 1'b1;
         end
         DP_SCAN_RD: begin
            bcnt_raddr = best_bid_ff;
            acnt_raddr = best_ask_ff;
         end
         DP_SCAN_CHK: begin
            if (!status.scan_stop) begin
               if (wside_ff == SIDE_BUY) best_bid_in = best_bid_ff - 1'b1;
               else best_ask_in = best_ask_ff + 1'b1;
            end
         end
         DP_TOP_RD: begin
            wside_in   = (op_ff == OP_REM_ASK);
            wlvl_in    = (op_ff == OP_REM_ASK) ? best_ask_ff : best_bid_ff;
            bcnt_raddr = best_bid_ff;
            acnt_raddr = best_ask_ff;
            pos_in     = '0;
         end
         DP_TOP_CHK: cnt_in = cnt_rd;
         DP_CHK_RD: begin
         end
         DP_CHK_DATA: marked_in = mark_rd_ff;
         DP_FIN_RD: begin
            bcnt_raddr = best_bid_ff;
            acnt_raddr = best_ask_ff;
            bid_raddr  = qaddr(best_bid_ff, '0);
            ask_raddr  = qaddr(best_ask_ff, '0);
         end
         DP_FIN_OUT: begin
            rsp_valid_in = 1'b1;
            o_status_in  = stat_ff;
            o_marked_in  = marked_ff;
            o_bvalid_in  = (bcnt_rd_ff != '0);
            o_bid_in     = (bcnt_rd_ff != '0) ? bid_rd_ff : 16'd0;
            o_bprice_in  = 10'(best_bid_ff);
            o_avalid_in  = (acnt_rd_ff != '0);
            o_ask_in     = (acnt_rd_ff != '0) ? ask_rd_ff : 16'd0;
            o_aprice_in  = 10'(best_ask_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (bcnt_we) bcnt_mem[cnt_waddr] <= cnt_wdata;
      bcnt_rd_ff <= bcnt_mem[bcnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (acnt_we) acnt_mem[cnt_waddr] <= cnt_wdata;
      acnt_rd_ff <= acnt_mem[acnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (bid_we) bid_mem[id_waddr] <= id_wdata;
      bid_rd_ff <= bid_mem[bid_raddr];
   end

   always_ff @(posedge clock) begin
      if (ask_we) ask_mem[id_waddr] <= id_wdata;
      ask_rd_ff <= ask_mem[ask_raddr];
   end

   always_ff @(posedge clock) begin
      if (idx_we) idx_mem[idx_waddr] <= idx_wdata;
      idx_rd_ff <= idx_mem[idx_addr];
   end

   always_ff @(posedge clock) begin
      if (mark_we) mark_mem[idx_waddr] <= mark_wdata;
      mark_rd_ff <= mark_mem[idx_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_bid_ff  <= '0;
         best_ask_ff  <= LW'(PRICE_LEVELS - 1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_bid_ff  <= best_bid_in;
         best_ask_ff  <= best_ask_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      oid_ff      <= oid_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      mod_k_ff    <= mod_k_in;
      wlvl_ff     <= wlvl_in;
      wside_ff    <= wside_in;
      pos_ff      <= pos_in;
      cnt_ff      <= cnt_in;
      stat_ff     <= stat_in;
      marked_ff   <= marked_in;
      o_status_ff <= o_status_in;
      o_marked_ff <= o_marked_in;
      o_bvalid_ff <= o_bvalid_in;
      o_bid_ff    <= o_bid_in;
      o_bprice_ff <= o_bprice_in;
      o_avalid_ff <= o_avalid_in;
      o_ask_ff    <= o_ask_in;
      o_aprice_ff <= o_aprice_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = o_status_ff;
   assign rsp_cancel_marked   = o_marked_ff;
   assign rsp_bid_valid       = o_bvalid_ff;
   assign rsp_bid_order_id    = o_bid_ff;
   assign rsp_bid_price_level = o_bprice_ff;
   assign rsp_ask_valid       = o_avalid_ff;
   assign rsp_ask_order_id    = o_ask_ff;
   assign rsp_ask_price_level = o_aprice_ff;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (bcnt_we || acnt_we) |-> (cnt_wdata <= CW'(LEVEL_DEPTH)))
      else $error("level count written beyond depth");

   a_no_add_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_ADD_WR) |-> !status.cnt_full)
      else $error("append issued into a full level");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.op == DP_FIN_OUT))
      else $error("result raised outside the finish step");

   a_bid_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_SCAN_CHK && wside_ff == SIDE_BUY && !status.scan_stop)
      |-> (best_bid_ff != '0))
      else $error("bid scan stepped below level zero");
`endif

endmodule

>>> design/limit_order_book_levels.sv
// Steps: add, check, an unused code and a cancel of an unindexed id need no search or scan;
// remove-top shifts the entries of the best level and rescans, unless that level is empty;
// cancel compares entries until a match, shifts the rest and rescans if the best level emptied.
// When ORDER_IDS is below 65536, each transaction adds an id reduction by reciprocal.
// Throughput: one transaction at a time, the next accepted in the cycle after the result loads.
// Reset: a clearing pass over max(PRICE_LEVELS, ORDER_IDS) entries, no input taken.
// ----------------------------------------------------------------------------
// limit_order_book_levels
// Price-time priority limit order book with per-level id queues, best bid
// and ask pointers, an id index and cancel marks.
// ----------------------------------------------------------------------------
module limit_order_book_levels #(
   parameter int PRICE_LEVELS = lobl_pkg::DEF_PRICE_LEVELS,
   parameter int LEVEL_DEPTH  = lobl_pkg::DEF_LEVEL_DEPTH,
   parameter int ORDER_IDS    = lobl_pkg::DEF_ORDER_IDS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // order_id[15:0], price_level[25:16], zero
   input  logic [3:0]  req_tuser,  // operation[2:0], side[3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // cancel_marked[0], bid_valid[1],
                                   // bid_order_id[17:2], bid_price_level[27:18],
                                   // ask_valid[28], ask_order_id[44:29],
                                   // ask_price_level[54:45], zero
   output logic [1:0]  rsp_tuser   // status[1:0]
);
   import lobl_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   logic        cancel_marked, bid_valid, ask_valid;
   logic [15:0] bid_order_id, ask_order_id;
   logic [9:0]  bid_price_level, ask_price_level;

   lobl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lobl_datapath #(
      .PRICE_LEVELS (PRICE_LEVELS),
      .LEVEL_DEPTH  (LEVEL_DEPTH),
      .ORDER_IDS    (ORDER_IDS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_tuser[2:0]),
      .req_order_id        (req_tdata[15:0]),
      .req_price_level     (req_tdata[25:16]),
      .req_side            (req_tuser[3]),
      .rsp_valid           (rsp_tvalid),
      .rsp_ready           (rsp_tready),
      .rsp_status          (rsp_tuser),
      .rsp_cancel_marked   (cancel_marked),
      .rsp_bid_valid       (bid_valid),
      .rsp_bid_order_id    (bid_order_id),
      .rsp_bid_price_level (bid_price_level),
      .rsp_ask_valid       (ask_valid),
      .rsp_ask_order_id    (ask_order_id),
      .rsp_ask_price_level (ask_price_level)
   );

   assign rsp_tdata = {1'b0, ask_price_level, ask_order_id, ask_valid,
                       bid_price_level, bid_order_id, bid_valid, cancel_marked};

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the limit order book level engine: directed and random
// transactions are checked against a behavioral book kept in the testbench.
// ----------------------------------------------------------------------------
module tb_top;
   import lobl_pkg::*;

   localparam int NLVL  = DEF_PRICE_LEVELS;
   localparam int DEPTH = DEF_LEVEL_DEPTH;
   localparam int WDOG  = 200000;
   localparam int EXPN  = 256;

   typedef struct packed {
      logic [1:0]  status;
      logic        marked;
      logic        bv;
      logic [15:0] bid;
      logic [9:0]  blvl;
      logic        av;
      logic [15:0] aid;
      logic [9:0]  alvl;
   } book_top_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   limit_order_book_levels dut (.*);

   always #5 clock = ~clock;

   // book image
   logic [15:0]  q_ids [2][NLVL][DEPTH];
   int           q_cnt [2][NLVL];
   int           best_bid, best_ask;
   bit           ix_valid [65536];
   bit           ix_side  [65536];
   int           ix_lvl   [65536];
   bit           marks    [65536];
   book_top_type exp_q [EXPN];
   int           exp_wr = 0;
   int           exp_rd = 0;
   int           errors = 0;
   int           idle_cycles = 0;
   int           rsp_gap = 0;
   bit           quiet = 0;
   bit           hold_rsp = 0;

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   function automatic void exp_put(book_top_type v);
      exp_q[exp_wr % EXPN] = v;
      exp_wr++;
   endfunction

   function automatic book_top_type exp_take();
      book_top_type v;
      v = exp_q[exp_rd % EXPN];
      exp_rd++;
      return v;
   endfunction

   function automatic void pop_at(int s, int l, int p);
      for (int i = p; i + 1 < q_cnt[s][l]; i++) q_ids[s][l][i] = q_ids[s][l][i+1];
      q_cnt[s][l]--;
   endfunction

   function automatic void rescan(int s);
      if (s == 0) while (best_bid > 0 && q_cnt[0][best_bid] == 0) best_bid--;
      else while (best_ask < NLVL - 1 && q_cnt[1][best_ask] == 0) best_ask++;
   endfunction

   function automatic book_top_type book_apply(logic [2:0] op, logic [15:0] id,
                                               logic [9:0] lvl, logic sd);
      book_top_type r;
      bit           found;
      int           s, l;
      r = '0;
      if (op == OP_ADD) begin
         if (q_cnt[sd][lvl] >= DEPTH) r.status = ST_FULL;
         else begin
            q_ids[sd][lvl][q_cnt[sd][lvl]] = id;
            q_cnt[sd][lvl]++;
            if (sd == SIDE_BUY) begin
               if (int'(lvl) > best_bid) best_bid = int'(lvl);
            end else if (int'(lvl) < best_ask) best_ask = int'(lvl);
            ix_valid[id] = 1; ix_side[id] = sd; ix_lvl[id] = int'(lvl);
         end
      end else if (op == OP_CANCEL) begin
         found = 0;
         marks[id] = 1;
         if (ix_valid[id]) begin
            s = int'(ix_side[id]); l = ix_lvl[id];
            for (int i = 0; i < q_cnt[s][l]; i++) begin
               if (q_ids[s][l][i] == id) begin
                  pop_at(s, l, i);
                  ix_valid[id] = 0; marks[id] = 0; found = 1;
                  if (q_cnt[s][l] == 0 && l == (s == 0 ? best_bid : best_ask)) rescan(s);
                  break;
               end
            end
         end
         if (!found) r.status = ST_NOT_FOUND;
      end else if (op == OP_REM_BID) begin
         if (q_cnt[0][best_bid] != 0) begin pop_at(0, best_bid, 0); rescan(0); end
      end else if (op == OP_REM_ASK) begin
         if (q_cnt[1][best_ask] != 0) begin pop_at(1, best_ask, 0); rescan(1); end
      end else if (op == OP_CHECK) r.marked = marks[id];
      r.bv = q_cnt[0][best_bid] != 0;
      r.bid = r.bv ? q_ids[0][best_bid][0] : 16'd0;
      r.blvl = 10'(best_bid);
      r.av = q_cnt[1][best_ask] != 0;
      r.aid = r.av ? q_ids[1][best_ask][0] : 16'd0;
      r.alvl = 10'(best_ask);
      return r;
   endfunction

   task automatic send_order(logic [2:0] op, logic [15:0] id, logic [9:0] lvl, logic sd);
      if (!quiet && $urandom_range(3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {6'd0, lvl, id};
      req_tuser  <= {sd, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      exp_put(book_apply(op, id, lvl, sd));
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_rsp) rsp_tready <= 0;
      else if (rsp_gap > 0) begin
         rsp_gap    <= rsp_gap - 1;
         rsp_tready <= 0;
      end else if (!quiet && $urandom_range(4) == 0) begin
         rsp_gap    <= int'($urandom_range(0, 6));
         rsp_tready <= 0;
      end else rsp_tready <= 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         book_top_type w;
         if (exp_wr == exp_rd) begin
            report("unexpected transaction", 1, 0);
         end else begin
            w = exp_take();
            if (rsp_tuser != w.status) report("status", rsp_tuser, w.status);
            if (rsp_tdata[0] != w.marked) report("cancel_marked", rsp_tdata[0], w.marked);
            if (rsp_tdata[1] != w.bv) report("bid_valid", rsp_tdata[1], w.bv);
            if (rsp_tdata[17:2] != w.bid) report("bid_order_id", rsp_tdata[17:2], w.bid);
            if (rsp_tdata[27:18] != w.blvl) report("bid_price_level", rsp_tdata[27:18], w.blvl);
            if (rsp_tdata[28] != w.av) report("ask_valid", rsp_tdata[28], w.av);
            if (rsp_tdata[44:29] != w.aid) report("ask_order_id", rsp_tdata[44:29], w.aid);
            if (rsp_tdata[54:45] != w.alvl) report("ask_price_level", rsp_tdata[54:45], w.alvl);
            if (rsp_tdata[55] != 1'b0) report("pad", rsp_tdata[55], 0);
         end
      end
   end

   // watchdog on stalled handshakes; clearing pass counts too, limit covers it
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic test_directed();
      send_order(OP_REM_BID, 0, 0, 0);
      send_order(OP_REM_ASK, 0, 0, 0);
      send_order(OP_ADD, 16'hFFFF, 10'h3FF, 0);
      send_order(OP_ADD, 16'h0000, 10'h000, 1);
      send_order(OP_ADD, 16'h1234, 10'd500, 0);
      send_order(OP_ADD, 16'h4321, 10'd600, 1);
      send_order(OP_CANCEL, 16'h1234, 0, 0);
      send_order(OP_CANCEL, 16'hAAAA, 0, 0);
      send_order(OP_CHECK, 16'hAAAA, 0, 0);
      send_order(OP_ADD, 16'hAAAA, 10'd3, 1);
      send_order(OP_CHECK, 16'hAAAA, 0, 1);
      send_order(OP_CANCEL, 16'hFFFF, 0, 0);
      send_order(OP_CANCEL, 16'h0000, 0, 0);
      send_order(OP_REM_ASK, 0, 0, 0);
      send_order(OP_CANCEL, 16'hAAAA, 0, 0);
      for (int i = 0; i < DEPTH + 1; i++) send_order(OP_ADD, 16'(16'h100 + i), 10'd20, 0);
      send_order(OP_ADD, 16'h5555, 10'd20, 0);
      send_order(3'd5, 16'h5555, 10'd1, 1);
      send_order(3'd7, 16'hFFFF, 10'h3FF, 1);
      send_order(OP_REM_BID, 0, 0, 0);
      send_order(OP_CHECK, 16'h101, 0, 0);
   endtask

   task automatic test_random(int n);
      logic [2:0] op;
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         op = k < 40 ? OP_ADD : k < 60 ? OP_CANCEL : k < 72 ? OP_REM_BID :
              k < 84 ? OP_REM_ASK : k < 96 ? OP_CHECK : 3'($urandom_range(5, 7));
         if ($urandom_range(9) == 0)
            send_order(op, 16'($urandom), 10'($urandom), 1'($urandom));
         else
            send_order(op, 16'($urandom_range(64)) | (16'($urandom_range(1)) << 15),
                       10'($urandom_range(500, 515)), 1'($urandom));
      end
   endtask

   task automatic test_backpressure();
      fork
         begin hold_rsp = 1; repeat (400) @(posedge clock); hold_rsp = 0; end
         test_random(30);
      join
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      best_bid = 0;
      best_ask = NLVL - 1;
      foreach (q_cnt[s, l]) q_cnt[s][l] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_random(1200);
      test_backpressure();
      quiet = 1;
      test_random(270);
      drain();
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

>>> sim.f
design/lobl_pkg.sv
design/lobl_ctrl.sv
design/lobl_datapath.sv
design/limit_order_book_levels.sv
dv/tb_top.sv
